// ===== rtl/sid_pkg.sv =====
// Shared constants and types for the signed integer divider.
// No dependencies; every other file in rtl/ imports this package.
package sid_pkg;

   localparam int DATA_WIDTH = 32;

   // Work item handed from cell to cell. rem holds the partial remainder,
   // num the dividend bits not yet consumed (MSB next), quo the quotient
   // bits produced so far (shifted in at the LSB).
   typedef struct packed {
      logic [DATA_WIDTH-1:0] rem;
      logic [DATA_WIDTH-1:0] num;
      logic [DATA_WIDTH-1:0] den;
      logic [DATA_WIDTH-1:0] quo;
      logic                  neg;
      logic                  dbz;
   } sid_work_type;

endpackage

// ===== rtl/sid_prep.sv =====
// Front stage of the divider: operand magnitudes, result sign, zero check.
// Depends on sid_pkg.
module sid_prep (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic signed [sid_pkg::DATA_WIDTH-1:0] in_dividend,
   input  logic signed [sid_pkg::DATA_WIDTH-1:0] in_divisor,
   output logic                                out_valid,
   input  logic                                out_ready,
   output sid_pkg::sid_work_type               out_data
);
   import sid_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   sid_work_type data_ff;
   sid_work_type data_in;
   logic         load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = load ? 1'b1 : (valid_ff && !out_ready);

   always_comb begin
      data_in     = '0;
      data_in.num = in_dividend[DATA_WIDTH-1] ? (~in_dividend + DATA_WIDTH'(1)) : in_dividend;
      data_in.den = in_divisor[DATA_WIDTH-1]  ? (~in_divisor + DATA_WIDTH'(1))  : in_divisor;
      data_in.neg = in_dividend[DATA_WIDTH-1] ^ in_divisor[DATA_WIDTH-1];
      data_in.dbz = (in_divisor == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/sid_cell.sv =====
// One restoring shift-subtract step: produces one quotient bit per item.
// Depends on sid_pkg.
module sid_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  sid_pkg::sid_work_type in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output sid_pkg::sid_work_type out_data
);
   import sid_pkg::*;

   logic          valid_ff;
   logic          valid_in;
   sid_work_type  data_ff;
   sid_work_type  data_in;
   logic          load;
   logic [DATA_WIDTH:0] trial;
   logic [DATA_WIDTH:0] diff;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = load ? 1'b1 : (valid_ff && !out_ready);

   always_comb begin
      trial   = {in_data.rem, in_data.num[DATA_WIDTH-1]};
      diff    = trial - {1'b0, in_data.den};
      data_in = in_data;
      data_in.num = {in_data.num[DATA_WIDTH-2:0], 1'b0};
      // No borrow means the shifted remainder covers the divisor.
      if (!diff[DATA_WIDTH]) begin
         data_in.rem = diff[DATA_WIDTH-1:0];
         data_in.quo = {in_data.quo[DATA_WIDTH-2:0], 1'b1};
      end else begin
         data_in.rem = trial[DATA_WIDTH-1:0];
         data_in.quo = {in_data.quo[DATA_WIDTH-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/signed_integer_divider_top.sv =====
// Signed integer divider, quotient truncated toward zero.
// The chain has one front stage, one cell per quotient bit and one output register.
// Throughput: one division per cycle while the output is not stalled; each stage holds one item, so the chain streams.
// A stalled output only backs up the stages behind it; bubbles are filled.
// Reset: synchronous, clears all stage valid flags; payload registers are not reset.
// Depends on sid_pkg, sid_prep and sid_cell.
module signed_integer_divider_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [sid_pkg::DATA_WIDTH-1:0]  req_dividend,
   input  logic signed [sid_pkg::DATA_WIDTH-1:0]  req_divisor,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [sid_pkg::DATA_WIDTH-1:0]  rsp_quotient,
   output logic                                   rsp_divide_by_zero
);
   import sid_pkg::*;

   // Chain links: index 0 is the front stage output, index DATA_WIDTH the last cell.
   logic         link_valid [DATA_WIDTH+1];
   logic         link_ready [DATA_WIDTH+1];
   sid_work_type link_data  [DATA_WIDTH+1];

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_quotient_ff;
   logic [DATA_WIDTH-1:0] rsp_quotient_in;
   logic                  rsp_dbz_ff;
   logic                  out_load;

   sid_prep u_prep (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .in_dividend (req_dividend),
      .in_divisor  (req_divisor),
      .out_valid   (link_valid[0]),
      .out_ready   (link_ready[0]),
      .out_data    (link_data[0])
   );

   for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
      sid_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[i]),
         .in_ready  (link_ready[i]),
         .in_data   (link_data[i]),
         .out_valid (link_valid[i+1]),
         .out_ready (link_ready[i+1]),
         .out_data  (link_data[i+1])
      );
   end

   assign link_ready[DATA_WIDTH] = !rsp_valid_ff || rsp_ready;
   assign out_load     = link_valid[DATA_WIDTH] && link_ready[DATA_WIDTH];
   assign rsp_valid_in = out_load ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   // Sign fix-up; zero divisor forces a zero quotient.
   always_comb begin
      if (link_data[DATA_WIDTH].dbz) begin
         rsp_quotient_in = '0;
      end else if (link_data[DATA_WIDTH].neg) begin
         rsp_quotient_in = ~link_data[DATA_WIDTH].quo + DATA_WIDTH'(1);
      end else begin
         rsp_quotient_in = link_data[DATA_WIDTH].quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_quotient_ff <= rsp_quotient_in;
         rsp_dbz_ff      <= link_data[DATA_WIDTH].dbz;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_quotient       = rsp_quotient_ff;
   assign rsp_divide_by_zero = rsp_dbz_ff;

endmodule

// ===== rtl/sid_checker.sv =====
// Port-level checks for signed_integer_divider_top, attached by bind.
// Depends on sid_pkg and the top level's port list.
module sid_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic signed [sid_pkg::DATA_WIDTH-1:0] rsp_quotient,
   input logic                                  rsp_divide_by_zero
);
   import sid_pkg::*;

   // Output channel empties on reset.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // A zero-divisor result always carries a zero quotient.
   a_dbz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_by_zero |-> rsp_quotient == '0)
      else $error("divide_by_zero with nonzero quotient");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped before transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_quotient) && $stable(rsp_divide_by_zero))
      else $error("rsp payload changed while stalled");

endmodule

bind signed_integer_divider_top sid_checker u_sid_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_quotient       (rsp_quotient),
   .rsp_divide_by_zero (rsp_divide_by_zero)
);

// ===== test/tb_signed_integer_divider_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for signed_integer_divider_top: directed table, then random operands.
// Depends on sid_pkg and the RTL under rtl/.
module tb_signed_integer_divider_top;
   import sid_pkg::*;

   localparam int W = DATA_WIDTH;
   localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MINUS_ONE = '1;
   localparam int ITEMS_PER_PHASE = 450;
   localparam int HOLD_CYCLES = 200;
   localparam int DRAIN_CYCLES = W + 8;
   localparam int WATCHDOG_LIMIT = 5000;

   typedef enum int {SHAPE_FULL, SHAPE_NARROW, SHAPE_TINY, SHAPE_CORNER} operand_shape_type;

   typedef struct packed {
      logic [W-1:0] quotient;
      logic         divide_by_zero;
   } quotient_result_type;

   typedef struct packed {
      logic [W-1:0] dividend;
      logic [W-1:0] divisor;
      bit           typed;
      logic [W-1:0] quotient;
      logic         divide_by_zero;
   } division_row_type;

   // typed = 0 rows take their expectation from the predictor
   localparam division_row_type DIRECTED_ROWS [25] = '{
      '{W'(7),        '0,        1'b1, '0,              1'b1},
      '{MOST_NEG,     '0,        1'b1, '0,              1'b1},
      '{MOST_POS,     '0,        1'b1, '0,              1'b1},
      '{MINUS_ONE,    '0,        1'b1, '0,              1'b1},
      '{'0,           '0,        1'b1, '0,              1'b1},
      '{MOST_NEG,     MOST_NEG,  1'b1, W'(1),           1'b0},
      '{MOST_POS,     MOST_NEG,  1'b1, '0,              1'b0},
      '{MINUS_ONE,    MOST_NEG,  1'b1, '0,              1'b0},
      '{W'(1),        MOST_NEG,  1'b1, '0,              1'b0},
      '{MOST_NEG,     MINUS_ONE, 1'b1, MOST_NEG,        1'b0},
      '{MOST_NEG,     W'(1),     1'b1, MOST_NEG,        1'b0},
      '{MOST_POS,     W'(1),     1'b1, MOST_POS,        1'b0},
      '{MOST_POS,     MINUS_ONE, 1'b1, MOST_NEG + W'(1), 1'b0},
      '{MOST_NEG,     MOST_POS,  1'b1, MINUS_ONE,       1'b0},
      '{MOST_POS,     MOST_POS,  1'b1, W'(1),           1'b0},
      '{'0,           MINUS_ONE, 1'b1, '0,              1'b0},
      '{W'(7),        W'(2),     1'b0, '0,              1'b0},
      '{W'(-7),       W'(2),     1'b0, '0,              1'b0},
      '{W'(7),        W'(-2),    1'b0, '0,              1'b0},
      '{W'(-7),       W'(-2),    1'b0, '0,              1'b0},
      '{MOST_NEG,     W'(3),     1'b0, '0,              1'b0},
      '{MOST_POS,     W'(-2),    1'b0, '0,              1'b0},
      '{W'(32'hdeadbeef), W'(32'h1235), 1'b0, '0,       1'b0},
      '{W'(12345678), W'(-321),  1'b0, '0,              1'b0},
      '{W'(32'h55555555), W'(32'haaaaaaaa), 1'b0, '0,   1'b0}
   };

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic signed [W-1:0] req_dividend = '0;
   logic signed [W-1:0] req_divisor = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic signed [W-1:0] rsp_quotient;
   logic                rsp_divide_by_zero;

   quotient_result_type offered_division = '0;
   quotient_result_type oldest;
   quotient_result_type expected_quotients [$];
   int                  mismatch_count = 0;
   int                  send_idle_pct = 9;
   int                  recv_idle_pct = 69;
   bit                  rsp_hold_request = 1'b0;
   int                  rsp_hold_left = 0;
   int                  quiet_cycles = 0;

   signed_integer_divider_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_dividend       (req_dividend),
      .req_divisor        (req_divisor),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_quotient       (rsp_quotient),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

   always #1 clock = ~clock;

   // Restoring shift-subtract on magnitudes, sign applied at the end.
   function automatic quotient_result_type divide_toward_zero(logic [W-1:0] dividend,
                                                              logic [W-1:0] divisor);
      quotient_result_type outcome;
      logic [W-1:0]        mag_num;
      logic [W-1:0]        mag_den;
      logic [W-1:0]        partial;
      logic [W-1:0]        quo;
      outcome = '0;
      if (divisor == '0) begin
         outcome.divide_by_zero = 1'b1;
         return outcome;
      end
      // most negative value maps onto itself, which is the right unsigned magnitude
      mag_num = dividend[W-1] ? -dividend : dividend;
      mag_den = divisor[W-1] ? -divisor : divisor;
      partial = '0;
      quo = '0;
      for (int i = W - 1; i >= 0; i--) begin
         partial = {partial[W-2:0], mag_num[i]};
         if (partial >= mag_den) begin
            partial = partial - mag_den;
            quo[i] = 1'b1;
         end
      end
      outcome.quotient = (dividend[W-1] ^ divisor[W-1]) ? -quo : quo;
      return outcome;
   endfunction

   function automatic logic [W-1:0] random_operand();
      logic [W-1:0]      value;
      operand_shape_type shape;
      int unsigned       pick;
      value = W'({$urandom, $urandom});
      pick = $urandom_range(99);
      shape = pick < 40 ? SHAPE_FULL : pick < 75 ? SHAPE_NARROW :
              pick < 90 ? SHAPE_TINY : SHAPE_CORNER;
      case (shape)
         SHAPE_FULL: ;
         SHAPE_NARROW: begin
            value = value >> $urandom_range(W - 1);
            if ($urandom_range(1) == 1) value = -value;
         end
         SHAPE_TINY: begin
            value = W'($urandom_range(8));
            if ($urandom_range(1) == 1) value = -value;
         end
         SHAPE_CORNER: begin
            case ($urandom_range(4))
               0: value = MOST_NEG;
               1: value = MOST_POS;
               2: value = MINUS_ONE;
               3: value = W'(1);
               default: value = '0;
            endcase
         end
      endcase
      return value;
   endfunction

   // Offer one division and return at the edge where it transfers.
   task automatic offer_division(input logic [W-1:0] dividend, input logic [W-1:0] divisor,
                                 input quotient_result_type outcome);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_dividend <= dividend;
      req_divisor <= divisor;
      offered_division <= outcome;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_quotients.size() != 0) @(posedge clock);
   endtask

   // Receiver: random backpressure, plus one long hold when asked.
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            rsp_hold_left = HOLD_CYCLES;
         end
         if (rsp_hold_left > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold_left--;
         end else begin
            rsp_ready <= $urandom_range(99) >= recv_idle_pct;
         end
      end
   end

   // Scoreboard: check the oldest expectation, then record a new transfer.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_quotients.size() == 0) begin
            $error("unexpected result: quotient %0d divide_by_zero %0b",
                   rsp_quotient, rsp_divide_by_zero);
            mismatch_count++;
         end else begin
            oldest = expected_quotients.pop_front();
            if (rsp_quotient !== oldest.quotient) begin
               $error("quotient: expected %0d, got %0d", $signed(oldest.quotient), rsp_quotient);
               mismatch_count++;
            end
            if (rsp_divide_by_zero !== oldest.divide_by_zero) begin
               $error("divide_by_zero: expected %0b, got %0b",
                      oldest.divide_by_zero, rsp_divide_by_zero);
               mismatch_count++;
            end
         end
      end
      if (!reset && req_valid && req_ready) expected_quotients.push_back(offered_division);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_signed_integer_divider_top: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [W-1:0] rand_dividend;
      logic [W-1:0] rand_divisor;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) begin
         offer_division(DIRECTED_ROWS[i].dividend, DIRECTED_ROWS[i].divisor,
                        DIRECTED_ROWS[i].typed ?
                           {DIRECTED_ROWS[i].quotient, DIRECTED_ROWS[i].divide_by_zero} :
                           divide_toward_zero(DIRECTED_ROWS[i].dividend,
                                              DIRECTED_ROWS[i].divisor));
      end
      wait_for_results();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = phase == 0 ? 9 : phase == 1 ? 69 : 0;
         recv_idle_pct = phase == 0 ? 69 : phase == 1 ? 9 : 0;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // fill the pipe against a stalled output while the sender keeps going
            if (phase == 2 && n == 100) rsp_hold_request = 1'b1;
            rand_dividend = random_operand();
            rand_divisor = random_operand();
            offer_division(rand_dividend, rand_divisor,
                           divide_toward_zero(rand_dividend, rand_divisor));
         end
         wait_for_results();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_quotients.size() == 0) begin
         $display("tb_signed_integer_divider_top: PASS");
      end else begin
         $display("tb_signed_integer_divider_top: FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/sid_pkg.sv
rtl/sid_prep.sv
rtl/sid_cell.sv
rtl/signed_integer_divider_top.sv
rtl/sid_checker.sv
test/tb_signed_integer_divider_top.sv
